// File: rtl/core/cell_balance_monitor_assert.svh
// Assertion macros used by the block's top-level RTL file.
`ifndef CELL_BALANCE_MONITOR_ASSERT_SVH
`define CELL_BALANCE_MONITOR_ASSERT_SVH

// Clocked check that is switched off while reset is held.
`define CBM_ASSERT(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);

// Clocked check that also holds during reset.
`define CBM_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// File: rtl/core/cbm_pkg.sv
package cbm_pkg;

  // Field widths.
  localparam int INPUT_CELLS  = 5;
  localparam int RAW_W        = 14;
  localparam int GAIN_W       = 9;
  localparam int OFF_W        = 8;
  localparam int MV_W         = 13;
  localparam int CELL_IDX_W   = 3;
  localparam int FLAGS_W      = 2;
  localparam int CLASS_W      = 2;
  localparam int CFG_IDX_W    = 3;
  localparam int CFG_DATA_W   = 13;
  localparam int CELL_SLOTS_DEF = 5;

  // Stream widths.
  localparam int IN_DATA_W  = 72;
  localparam int OUT_DATA_W = 40;

  // Conversion arithmetic: raw * gain + offset * 1000, then divide by 1000.
  localparam int PROD_W       = RAW_W + GAIN_W;
  localparam int SUM_W        = 25;
  localparam int MAG_W        = SUM_W - 1;
  localparam int RECIP_SHIFT  = 34;
  localparam int RECIP_W      = 25;
  localparam int QPROD_W      = MAG_W + RECIP_W;
  localparam int Q_W          = QPROD_W - RECIP_SHIFT;
  localparam logic [RECIP_W-1:0] RECIP = 25'd17179870;
  localparam logic signed [SUM_W-1:0] OFF_SCALE = 25'sd1000;
  localparam logic [MV_W-1:0] MV_MAX = 13'd8191;

  // Register reset values.
  localparam logic [GAIN_W-1:0]     GAIN_RST      = 9'd380;
  localparam logic [OFF_W-1:0]      OFFSET_RST    = 8'd0;
  localparam logic [INPUT_CELLS-1:0] POP_RST      = 5'd19;
  localparam logic [MV_W-1:0]       BAL_START_RST = 13'd50;
  localparam logic [MV_W-1:0]       BAL_END_RST   = 13'd20;
  localparam logic [MV_W-1:0]       OVER_RST      = 13'd4200;
  localparam logic [MV_W-1:0]       UNDER_RST     = 13'd3000;
  localparam logic [MV_W-1:0]       RECOV_RST     = 13'd3300;

  // Configuration register indexes.
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_GAIN      = 3'd0,
    CFG_OFFSET    = 3'd1,
    CFG_POPULATED = 3'd2,
    CFG_BAL_START = 3'd3,
    CFG_BAL_END   = 3'd4,
    CFG_OVER      = 3'd5,
    CFG_UNDER     = 3'd6,
    CFG_RECOVERY  = 3'd7
  } cbm_cfg_idx_t;

  // Trip classes.
  localparam logic [CLASS_W-1:0] TRIP_HEALTHY = 2'd0;

  // Load strobes of the lane pipeline stages.
  typedef struct packed {
    logic s1;
    logic s2;
    logic s3;
  } cbm_adv_t;

  // Voltage limits used by the merging stage.
  typedef struct packed {
    logic [MV_W-1:0] over_mv;
    logic [MV_W-1:0] under_mv;
    logic [MV_W-1:0] recovery_mv;
  } cbm_limits_t;

  // What the merging stage found over the populated cells.
  typedef struct packed {
    logic [MV_W-1:0]       min_mv;
    logic [MV_W-1:0]       max_mv;
    logic [CELL_IDX_W-1:0] max_cell;
    logic                  ov;
    logic                  uv;
    logic                  recovered;
  } cbm_stats_t;

endpackage

// File: rtl/core/cbm_lane.sv
module cbm_lane
  import cbm_pkg::*;
(
  input  logic              clk,
  input  cbm_adv_t          adv,
  input  logic [RAW_W-1:0]  raw,
  input  logic [GAIN_W-1:0] gain,
  input  logic signed [OFF_W-1:0] offset,
  output logic [MV_W-1:0]   mv
);

  logic [PROD_W-1:0]       prod;
  logic signed [SUM_W-1:0] off_scaled;
  logic signed [SUM_W-1:0] sum_nxt, sum_r;
  logic [QPROD_W-1:0]      qprod_nxt, qprod_r;
  logic                    neg_nxt, neg_r;
  logic [Q_W-1:0]          quot;
  logic [MV_W-1:0]         mv_nxt, mv_r;

  // Stage 1: scale the raw count and add the offset in microvolts.
  always_comb begin
    prod       = PROD_W'(raw) * PROD_W'(gain);
    off_scaled = SUM_W'(offset) * OFF_SCALE;
    sum_nxt    = $signed(SUM_W'(prod)) + off_scaled;
  end

  // Stage 2: divide by 1000 through a multiply by the scaled reciprocal.
  always_comb begin
    neg_nxt   = sum_r[SUM_W-1];
    qprod_nxt = QPROD_W'(sum_r[MAG_W-1:0]) * QPROD_W'(RECIP);
  end

  // Stage 3: drop the fraction, clamp negatives to zero and saturate.
  always_comb begin
    quot = qprod_r[QPROD_W-1:RECIP_SHIFT];
    if (neg_r) begin
      mv_nxt = '0;
    end else if (quot > Q_W'(MV_MAX)) begin
      mv_nxt = MV_MAX;
    end else begin
      mv_nxt = quot[MV_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (adv.s1) begin
      sum_r <= sum_nxt;
    end
    if (adv.s2) begin
      qprod_r <= qprod_nxt;
      neg_r   <= neg_nxt;
    end
    if (adv.s3) begin
      mv_r <= mv_nxt;
    end
  end

  assign mv = mv_r;

endmodule

// File: rtl/core/cbm_merge.sv
module cbm_merge
  import cbm_pkg::*;
#(
  parameter int LANES = CELL_SLOTS_DEF
) (
  input  logic             clk,
  input  logic             load,
  input  logic [MV_W-1:0]  lane_mv [LANES],
  input  logic [LANES-1:0] populated,
  input  cbm_limits_t      limits,
  output cbm_stats_t       stats
);

  cbm_stats_t stats_nxt, stats_r;

  // Walk the lanes in order; the first populated cell seeds min and max,
  // and a later cell takes the max only when strictly higher.
  always_comb begin
    logic seen;
    seen      = 1'b0;
    stats_nxt = '0;
    stats_nxt.recovered = 1'b1;
    for (int i = 0; i < LANES; i++) begin
      if (populated[i]) begin
        if (!seen) begin
          stats_nxt.min_mv   = lane_mv[i];
          stats_nxt.max_mv   = lane_mv[i];
          stats_nxt.max_cell = CELL_IDX_W'(i);
          seen = 1'b1;
        end else begin
          if (lane_mv[i] < stats_nxt.min_mv) begin
            stats_nxt.min_mv = lane_mv[i];
          end
          if (lane_mv[i] > stats_nxt.max_mv) begin
            stats_nxt.max_mv   = lane_mv[i];
            stats_nxt.max_cell = CELL_IDX_W'(i);
          end
        end
        if (lane_mv[i] >= limits.over_mv) begin
          stats_nxt.ov = 1'b1;
        end
        if (lane_mv[i] <= limits.under_mv) begin
          stats_nxt.uv = 1'b1;
        end
        if (lane_mv[i] <= limits.recovery_mv) begin
          stats_nxt.recovered = 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      stats_r <= stats_nxt;
    end
  end

  assign stats = stats_r;

endmodule

// File: rtl/core/cell_balance_monitor.sv
// Cell balance monitor.
// Input channel in_*: one beat is one measurement frame, five raw 14-bit
// cell readings and the two chip trip flags. Result channel out_*: one beat
// per frame with the drain mask, balancing flag, max cell, min/max voltage,
// trip class, clear-trip request and undervoltage recovery.
// Configuration port cfg_*: writes one register per beat; it is always
// ready and is meant to be written while no frame is in flight.
// Pipeline: five register stages hold a frame in turn (three lane stages
// for conversion, one merge stage, one output register); the first loads
// at the edge that accepts the frame.
// Throughput: one frame per cycle unless the receiver stalls; each lane
// converts one cell, with its multiply-add and reciprocal multiply in
// separate stages. When the receiver stalls, the result is held and
// frames keep entering until every stage holds one; then in_tready drops.
// Reset (synchronous, active low) loads the register defaults, empties
// the pipeline and clears the balancing flag.
`include "cell_balance_monitor_assert.svh"

module cell_balance_monitor
  import cbm_pkg::*;
#(
  parameter int CELL_SLOTS = CELL_SLOTS_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  // Fields from bit 0: cell0_raw, cell1_raw, cell2_raw, cell3_raw,
  // cell4_raw (14 bits each), trip_flags (2 bits).
  input  logic [IN_DATA_W-1:0]  in_tdata,
  input  logic                  in_tvalid,
  output logic                  in_tready,
  // Fields from bit 0: drain_mask (5), is_balancing (1), max_cell (3),
  // min_mv (13), max_mv (13), trip_class (2), clear_trip (1),
  // uv_recovered (1), one pad bit.
  output logic [OUT_DATA_W-1:0] out_tdata,
  output logic                  out_tvalid,
  input  logic                  out_tready,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  localparam int LANES = (CELL_SLOTS < INPUT_CELLS) ? CELL_SLOTS : INPUT_CELLS;

  // Configuration registers.
  logic [GAIN_W-1:0]       gain_r;
  logic signed [OFF_W-1:0] offset_r;
  logic [INPUT_CELLS-1:0]  populated_r;
  logic [MV_W-1:0]         bal_start_r, bal_end_r, over_r, under_r, recov_r;

  // Pipeline occupancy and trip flags travelling with each frame.
  logic                v1_r, v2_r, v3_r, v4_r, out_valid_r;
  logic                rdy1, rdy2, rdy3, rdy4, rdy5;
  logic                load1, load2, load3, load4, load5;
  logic [FLAGS_W-1:0]  flags1_r, flags2_r, flags3_r, flags4_r;
  logic                balancing_r, balancing_nxt;

  cbm_adv_t            adv;
  cbm_limits_t         limits;
  cbm_stats_t          stats;
  logic [MV_W-1:0]     lane_mv [LANES];

  // Result fields.
  logic [INPUT_CELLS-1:0] drain_nxt, drain_r;
  logic [CELL_IDX_W-1:0]  max_cell_r;
  logic [MV_W-1:0]        min_r, max_r, spread;
  logic [CLASS_W-1:0]     class_nxt, class_r;
  logic                   clear_nxt, clear_r, recov_out_r;

  // Each stage takes a new frame when empty or when its contents move on.
  always_comb begin
    rdy5  = !out_valid_r || out_tready;
    rdy4  = !v4_r || rdy5;
    rdy3  = !v3_r || rdy4;
    rdy2  = !v2_r || rdy3;
    rdy1  = !v1_r || rdy2;
    load1 = in_tvalid && rdy1;
    load2 = v1_r && rdy2;
    load3 = v2_r && rdy3;
    load4 = v3_r && rdy4;
    load5 = v4_r && rdy5;
  end

  assign in_tready = rdy1;
  assign cfg_ready = 1'b1;
  assign adv       = '{s1: load1, s2: load2, s3: load3};
  assign limits    = '{over_mv: over_r, under_mv: under_r, recovery_mv: recov_r};

  // Conversion lanes, one per cell position.
  for (genvar g = 0; g < LANES; g++) begin : g_lane
    cbm_lane u_lane (
      .clk    (clk),
      .adv    (adv),
      .raw    (in_tdata[g*RAW_W +: RAW_W]),
      .gain   (gain_r),
      .offset (offset_r),
      .mv     (lane_mv[g])
    );
  end

  cbm_merge #(
    .LANES (LANES)
  ) u_merge (
    .clk       (clk),
    .load      (load4),
    .lane_mv   (lane_mv),
    .populated (populated_r[LANES-1:0]),
    .limits    (limits),
    .stats     (stats)
  );

  // Hysteresis on the spread, drain mask and trip classification.
  always_comb begin
    spread = stats.max_mv - stats.min_mv;
    if (balancing_r) begin
      balancing_nxt = spread > bal_end_r;
    end else begin
      balancing_nxt = spread > bal_start_r;
    end
    drain_nxt = balancing_nxt ? (INPUT_CELLS'(1) << stats.max_cell) : '0;
    class_nxt = TRIP_HEALTHY;
    clear_nxt = 1'b0;
    if (flags4_r != '0) begin
      class_nxt = {stats.uv, stats.ov};
      clear_nxt = ({stats.uv, stats.ov} == TRIP_HEALTHY);
    end
  end

  // Control state and configuration registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r        <= 1'b0;
      v2_r        <= 1'b0;
      v3_r        <= 1'b0;
      v4_r        <= 1'b0;
      out_valid_r <= 1'b0;
      balancing_r <= 1'b0;
      gain_r      <= GAIN_RST;
      offset_r    <= OFFSET_RST;
      populated_r <= POP_RST;
      bal_start_r <= BAL_START_RST;
      bal_end_r   <= BAL_END_RST;
      over_r      <= OVER_RST;
      under_r     <= UNDER_RST;
      recov_r     <= RECOV_RST;
    end else begin
      v1_r        <= load1 || (v1_r && !rdy2);
      v2_r        <= load2 || (v2_r && !rdy3);
      v3_r        <= load3 || (v3_r && !rdy4);
      v4_r        <= load4 || (v4_r && !rdy5);
      out_valid_r <= load5 || (out_valid_r && !out_tready);
      if (load5) begin
        balancing_r <= balancing_nxt;
      end
      if (cfg_valid) begin
        case (cbm_cfg_idx_t'(cfg_index))
          CFG_GAIN:      gain_r      <= cfg_data[GAIN_W-1:0];
          CFG_OFFSET:    offset_r    <= cfg_data[OFF_W-1:0];
          CFG_POPULATED: populated_r <= cfg_data[INPUT_CELLS-1:0];
          CFG_BAL_START: bal_start_r <= cfg_data[MV_W-1:0];
          CFG_BAL_END:   bal_end_r   <= cfg_data[MV_W-1:0];
          CFG_OVER:      over_r      <= cfg_data[MV_W-1:0];
          CFG_UNDER:     under_r     <= cfg_data[MV_W-1:0];
          CFG_RECOVERY:  recov_r     <= cfg_data[MV_W-1:0];
          default: ;
        endcase
      end
    end
  end

  // Payload registers: trip flags follow the frame, results load at the end.
  always_ff @(posedge clk) begin
    if (load1) begin
      flags1_r <= in_tdata[INPUT_CELLS*RAW_W +: FLAGS_W];
    end
    if (load2) begin
      flags2_r <= flags1_r;
    end
    if (load3) begin
      flags3_r <= flags2_r;
    end
    if (load4) begin
      flags4_r <= flags3_r;
    end
    if (load5) begin
      drain_r     <= drain_nxt;
      max_cell_r  <= stats.max_cell;
      min_r       <= stats.min_mv;
      max_r       <= stats.max_mv;
      class_r     <= class_nxt;
      clear_r     <= clear_nxt;
      recov_out_r <= stats.recovered;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {1'b0, recov_out_r, clear_r, class_r, max_r, min_r,
                       max_cell_r, balancing_r, drain_r};

  // Checks on the result, the kept balancing flag, input stalls and reset.
  `CBM_ASSERT(a_drain_mask, clk, rst_n,
    out_valid_r |-> ($onehot0(drain_r) && ((drain_r != '0) == balancing_r)),
    "drain mask disagrees with balancing flag")
  `CBM_ASSERT(a_min_le_max, clk, rst_n, out_valid_r |-> (min_r <= max_r),
    "min voltage above max voltage")
  `CBM_ASSERT(a_clear_healthy, clk, rst_n,
    (out_valid_r && clear_r) |-> (class_r == TRIP_HEALTHY),
    "clear-trip request with a confirmed trip")
  `CBM_ASSERT(a_full_stall, clk, rst_n,
    (!in_tready) |-> (v1_r && v2_r && v3_r && v4_r && out_valid_r),
    "input stalled while a stage is empty")
  `CBM_ASSERT_ALWAYS(a_reset_empty, clk,
    (!rst_n) |=> (!out_valid_r && !v4_r && !balancing_r),
    "pipeline not empty after reset")

endmodule
